FILE: hw/rtl/cste_pkg.sv
// Shared types and constants for the clock set-time editor.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps

package cste_pkg;

   // Command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_BUTTON = 1'b1;

   // Button codes
   typedef enum logic [1:0] {
      BTN_BACK = 2'd0,
      BTN_UP   = 2'd1,
      BTN_DOWN = 2'd2,
      BTN_NEXT = 2'd3
   } btn_type;

   // Editing positions
   typedef logic [2:0] pos_type;
   localparam pos_type POS_HOURS   = 3'd0;
   localparam pos_type POS_MINUTES = 3'd1;
   localparam pos_type POS_SECONDS = 3'd2;
   localparam pos_type POS_WEEKDAY = 3'd3;
   localparam pos_type POS_DATE    = 3'd4;
   localparam pos_type POS_MONTH   = 3'd5;
   localparam pos_type POS_YEAR    = 3'd6;
   localparam pos_type POS_REVIEW  = 3'd7;

   // Legal range per field: low bound and one past the high bound
   localparam logic [6:0] HOURS_LO   = 7'd0;
   localparam logic [6:0] HOURS_LIM  = 7'd24;
   localparam logic [6:0] MINSEC_LO  = 7'd0;
   localparam logic [6:0] MINSEC_LIM = 7'd60;
   localparam logic [6:0] WEEKDAY_LO  = 7'd1;
   localparam logic [6:0] WEEKDAY_LIM = 7'd8;
   localparam logic [6:0] DATE_LO    = 7'd1;
   localparam logic [6:0] DATE_LIM   = 7'd32;
   localparam logic [6:0] MONTH_LO   = 7'd1;
   localparam logic [6:0] MONTH_LIM  = 7'd13;
   localparam logic [6:0] YEAR_LO    = 7'd0;
   localparam logic [6:0] YEAR_LIM   = 7'd100;

   // Seven edit registers
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [2:0] weekday;
      logic [4:0] date;
      logic [3:0] month;
      logic [6:0] year;
   } time_type;

   // Input item
   typedef struct packed {
      logic       cmd;
      btn_type    button;
      logic [4:0] load_hours;
      logic [5:0] load_minutes;
      logic [5:0] load_seconds;
      logic [2:0] load_weekday;
      logic [4:0] load_date;
      logic [3:0] load_month;
      logic [6:0] load_year;
   } req_type;

   // Result item
   typedef struct packed {
      pos_type    field_selected;
      logic [4:0] edit_hours;
      logic [5:0] edit_minutes;
      logic [5:0] edit_seconds;
      logic [2:0] edit_weekday;
      logic [4:0] edit_date;
      logic [3:0] edit_month;
      logic [6:0] edit_year;
      logic       commit_time;
      logic       leave_menu;
   } rsp_type;

   // Up/down step with wrap inside lo .. lim-1; caller truncates to field width.
   // Values loaded out of range: up wraps to lo, down gives value-1 above lo.
   function automatic logic [6:0] step_field(input logic [6:0] value,
                                             input logic [6:0] lo,
                                             input logic [6:0] lim,
                                             input btn_type    btn);
      logic [7:0] incr;
      logic [6:0] result;
      incr   = {1'b0, value} + 8'd1;
      result = value;
      if (btn == BTN_UP) begin
         result = (incr >= {1'b0, lim}) ? lo : incr[6:0];
      end else if (btn == BTN_DOWN) begin
         result = (value <= lo) ? (lim - 7'd1) : (value - 7'd1);
      end
      return result;
   endfunction

endpackage

FILE: hw/rtl/cste_if.sv
// Valid/ready channel interfaces for the set-time editor requests and results.
// Depends on cste_pkg for the payload types.
`timescale 1ns / 1ps

interface cste_req_if;
   import cste_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cste_rsp_if;
   import cste_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cste_in_stage.sv
// Input register stage: captures one request per cycle and holds it under stall.
// Depends on cste_pkg and cste_req_if.
`timescale 1ns / 1ps

module cste_in_stage (
   input  logic       clock,
   input  logic       reset,
   cste_req_if.sink   in_link,
   cste_req_if.source out_link
);
   import cste_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   // Accept when empty or when the held item moves on this cycle
   assign in_link.ready = !valid_ff || out_link.ready;
   assign take          = in_link.valid && in_link.ready;
   assign valid_in      = take ? 1'b1 : (out_link.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= in_link.data;
      end
   end

   assign out_link.valid = valid_ff;
   assign out_link.data  = data_ff;

endmodule

FILE: hw/rtl/cste_edit_core.sv
// Edit state, single-pass update logic and the result register.
// Depends on cste_pkg, cste_req_if and cste_rsp_if.
`timescale 1ns / 1ps

module cste_edit_core (
   input  logic       clock,
   input  logic       reset,
   cste_req_if.sink   in_link,
   cste_rsp_if.source out_link
);
   import cste_pkg::*;

   pos_type  pos_ff;
   pos_type  pos_in;
   time_type edit_ff;
   time_type edit_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_data_ff;
   rsp_type  rsp_data_in;
   logic     commit;
   logic     leave;
   logic     fire;
   req_type  req;

   assign req           = in_link.data;
   assign in_link.ready = !rsp_valid_ff || out_link.ready;
   assign fire          = in_link.valid && in_link.ready;

   // Next edit state for the item at the head of the input stage
   always_comb begin
      pos_in  = pos_ff;
      edit_in = edit_ff;
      commit  = 1'b0;
      leave   = 1'b0;
      if (req.cmd == CMD_LOAD) begin
         edit_in.hours   = req.load_hours;
         edit_in.minutes = req.load_minutes;
         edit_in.seconds = req.load_seconds;
         edit_in.weekday = req.load_weekday;
         edit_in.date    = req.load_date;
         edit_in.month   = req.load_month;
         edit_in.year    = req.load_year;
         pos_in          = POS_HOURS;
      end else begin
         case (req.button)
            BTN_BACK: begin
               if (pos_ff != POS_HOURS) pos_in = pos_ff - 3'd1;
            end
            BTN_NEXT: begin
               if (pos_ff != POS_REVIEW) pos_in = pos_ff + 3'd1;
            end
            default: begin
               if (pos_ff == POS_REVIEW) begin
                  leave  = 1'b1;
                  commit = (req.button == BTN_UP);
               end else begin
                  case (pos_ff)
                     POS_HOURS: begin
                        edit_in.hours = 5'(step_field({2'b0, edit_ff.hours},
                                                      HOURS_LO, HOURS_LIM, req.button));
                     end
                     POS_MINUTES: begin
                        edit_in.minutes = 6'(step_field({1'b0, edit_ff.minutes},
                                                        MINSEC_LO, MINSEC_LIM,
                                                        req.button));
                     end
                     POS_SECONDS: begin
                        edit_in.seconds = 6'(step_field({1'b0, edit_ff.seconds},
                                                        MINSEC_LO, MINSEC_LIM,
                                                        req.button));
                     end
                     POS_WEEKDAY: begin
                        edit_in.weekday = 3'(step_field({4'b0, edit_ff.weekday},
                                                        WEEKDAY_LO, WEEKDAY_LIM,
                                                        req.button));
                     end
                     POS_DATE: begin
                        edit_in.date = 5'(step_field({2'b0, edit_ff.date},
                                                     DATE_LO, DATE_LIM, req.button));
                     end
                     POS_MONTH: begin
                        edit_in.month = 4'(step_field({3'b0, edit_ff.month},
                                                      MONTH_LO, MONTH_LIM, req.button));
                     end
                     POS_YEAR: begin
                        edit_in.year = step_field(edit_ff.year,
                                                  YEAR_LO, YEAR_LIM, req.button);
                     end
                     default: begin
                        edit_in = edit_ff;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   // Result built from the post-item state
   always_comb begin
      rsp_data_in.field_selected = pos_in;
      rsp_data_in.edit_hours     = edit_in.hours;
      rsp_data_in.edit_minutes   = edit_in.minutes;
      rsp_data_in.edit_seconds   = edit_in.seconds;
      rsp_data_in.edit_weekday   = edit_in.weekday;
      rsp_data_in.edit_date      = edit_in.date;
      rsp_data_in.edit_month     = edit_in.month;
      rsp_data_in.edit_year      = edit_in.year;
      rsp_data_in.commit_time    = commit;
      rsp_data_in.leave_menu     = leave;
   end

   assign rsp_valid_in = fire ? 1'b1 : (out_link.ready ? 1'b0 : rsp_valid_ff);

   // Edit state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= POS_HOURS;
         edit_ff.hours   <= 5'd0;
         edit_ff.minutes <= 6'd0;
         edit_ff.seconds <= 6'd0;
         edit_ff.weekday <= 3'd1;
         edit_ff.date    <= 5'd1;
         edit_ff.month   <= 4'd1;
         edit_ff.year    <= 7'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            pos_ff  <= pos_in;
            edit_ff <= edit_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign out_link.valid = rsp_valid_ff;
   assign out_link.data  = rsp_data_ff;

endmodule

FILE: hw/rtl/clock_set_time_editor_unit.sv
// Top level of the clock set-time editor: input stage followed by edit core.
// Depends on cste_pkg, cste_if, cste_in_stage and cste_edit_core.
`timescale 1ns / 1ps

// Set-time editor for a clock. Each request is either a load (copy the
// current time into the edit registers, select hours) or a button press
// (back, up, down, next). Every request produces exactly one response that
// carries the selected field, all seven edit values, and the commit/exit
// flags raised by up or down at the review position. Throughput is one
// request per cycle without backpressure. A request passes through the
// input and response registers in turn, with the field update done in the
// single combinational pass between them. Backpressure on the response
// side stalls both registers without losing or repeating a transfer.

module clock_set_time_editor_unit (
   input  logic       clock,
   input  logic       reset,
   cste_req_if.sink   req_bus,
   cste_rsp_if.source rsp_bus
);
   import cste_pkg::*;

   cste_req_if core_link ();

   cste_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_link  (req_bus),
      .out_link (core_link)
   );

   cste_edit_core u_edit_core (
      .clock    (clock),
      .reset    (reset),
      .in_link  (core_link),
      .out_link (rsp_bus)
   );

   // A commit is always accompanied by an exit
   a_commit_leaves: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.commit_time |-> rsp_bus.data.leave_menu)
      else $error("commit without leave");

   // Exit is only raised at the review position
   a_leave_at_review: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.leave_menu |->
         rsp_bus.data.field_selected == POS_REVIEW)
      else $error("leave outside review");

   // A load transfer into the core returns to hours on the next response
   a_load_to_hours: assert property (@(posedge clock) disable iff (reset)
      core_link.valid && core_link.ready && core_link.data.cmd == CMD_LOAD |=>
         rsp_bus.valid && rsp_bus.data.field_selected == POS_HOURS &&
         !rsp_bus.data.leave_menu)
      else $error("load did not select hours");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for clock_set_time_editor_unit: load and button transfers in, one response out.
// Depends on cste_pkg, the cste_req_if / cste_rsp_if interfaces and the unit's RTL.

module tb_top;
   import cste_pkg::*;

   localparam int CLK_HALF_NS     = 6;
   localparam int RESET_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int MAX_REPORTS     = 40;
   localparam int REQ_BITS        = $bits(req_type);

   logic clock;
   logic reset;

   cste_req_if req_bus();
   cste_rsp_if rsp_bus();

   clock_set_time_editor_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the editor: selected field and the seven edit values
   pos_type     sel_pos;
   time_type    edit_time;
   rsp_type     expected_edits[$];

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned items_sent;
   int unsigned loads_seen;
   int unsigned presses_seen;
   int unsigned commits_seen;
   int unsigned leaves_seen;
   int unsigned error_count;
   int unsigned cycle_count;

   always begin
      clock = 1'b0;
      #CLK_HALF_NS;
      clock = 1'b1;
      #CLK_HALF_NS;
   end

   // Up/down step with wrap inside lo..hi; out-of-range values follow the same compare
   function automatic int unsigned wrap_step(int unsigned value, int unsigned lo,
                                             int unsigned hi, btn_type btn);
      if (btn == BTN_UP) begin
         return (value >= hi) ? lo : value + 1;
      end
      return (value <= lo) ? hi : value - 1;
   endfunction

   // Apply one accepted transfer to the shadow state and build the response it causes
   function automatic rsp_type predict_edit_response(req_type item);
      rsp_type rsp;
      rsp = '0;
      if (item.cmd == CMD_LOAD) begin
         edit_time.hours   = item.load_hours;
         edit_time.minutes = item.load_minutes;
         edit_time.seconds = item.load_seconds;
         edit_time.weekday = item.load_weekday;
         edit_time.date    = item.load_date;
         edit_time.month   = item.load_month;
         edit_time.year    = item.load_year;
         sel_pos = POS_HOURS;
      end else begin
         case (item.button)
            BTN_BACK: begin
               if (sel_pos != POS_HOURS) sel_pos = sel_pos - 3'd1;
            end
            BTN_NEXT: begin
               if (sel_pos != POS_REVIEW) sel_pos = sel_pos + 3'd1;
            end
            default: begin
               case (sel_pos)
                  POS_HOURS: begin
                     edit_time.hours = 5'(wrap_step(edit_time.hours, HOURS_LO,
                                                    HOURS_LIM - 1, item.button));
                  end
                  POS_MINUTES: begin
                     edit_time.minutes = 6'(wrap_step(edit_time.minutes, MINSEC_LO,
                                                      MINSEC_LIM - 1, item.button));
                  end
                  POS_SECONDS: begin
                     edit_time.seconds = 6'(wrap_step(edit_time.seconds, MINSEC_LO,
                                                      MINSEC_LIM - 1, item.button));
                  end
                  POS_WEEKDAY: begin
                     edit_time.weekday = 3'(wrap_step(edit_time.weekday, WEEKDAY_LO,
                                                      WEEKDAY_LIM - 1, item.button));
                  end
                  POS_DATE: begin
                     edit_time.date = 5'(wrap_step(edit_time.date, DATE_LO,
                                                   DATE_LIM - 1, item.button));
                  end
                  POS_MONTH: begin
                     edit_time.month = 4'(wrap_step(edit_time.month, MONTH_LO,
                                                    MONTH_LIM - 1, item.button));
                  end
                  POS_YEAR: begin
                     edit_time.year = 7'(wrap_step(edit_time.year, YEAR_LO,
                                                   YEAR_LIM - 1, item.button));
                  end
                  default: begin
                     // review: up confirms and exits, down cancels
                     rsp.leave_menu  = 1'b1;
                     rsp.commit_time = (item.button == BTN_UP);
                  end
               endcase
            end
         endcase
      end
      rsp.field_selected = sel_pos;
      rsp.edit_hours     = edit_time.hours;
      rsp.edit_minutes   = edit_time.minutes;
      rsp.edit_seconds   = edit_time.seconds;
      rsp.edit_weekday   = edit_time.weekday;
      rsp.edit_date      = edit_time.date;
      rsp.edit_month     = edit_time.month;
      rsp.edit_year      = edit_time.year;
      return rsp;
   endfunction

   task automatic check_field(string label, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         end
      end
   endtask

   // Response check first, then prediction of the request transfer at the same edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = rsp_bus.data;
         if (expected_edits.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: response with nothing pending, expected none, actual %p",
                        $time, got);
            end
         end else begin
            want = expected_edits.pop_front();
            check_field("field_selected", want.field_selected, got.field_selected);
            check_field("edit_hours",     want.edit_hours,     got.edit_hours);
            check_field("edit_minutes",   want.edit_minutes,   got.edit_minutes);
            check_field("edit_seconds",   want.edit_seconds,   got.edit_seconds);
            check_field("edit_weekday",   want.edit_weekday,   got.edit_weekday);
            check_field("edit_date",      want.edit_date,      got.edit_date);
            check_field("edit_month",     want.edit_month,     got.edit_month);
            check_field("edit_year",      want.edit_year,      got.edit_year);
            check_field("commit_time",    want.commit_time,    got.commit_time);
            check_field("leave_menu",     want.leave_menu,     got.leave_menu);
         end
      end
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         want = predict_edit_response(req_bus.data);
         expected_edits.push_back(want);
         if (req_bus.data.cmd == CMD_LOAD) loads_seen++;
         else presses_seen++;
         if (want.commit_time) commits_seen++;
         if (want.leave_menu) leaves_seen++;
      end
   end

   // Response-side stalls
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still pending",
                  cycle_count, expected_edits.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic req_type make_load(int unsigned hh, int unsigned mm, int unsigned ss,
                                         int unsigned wd, int unsigned dd, int unsigned mo,
                                         int unsigned yy);
      req_type item;
      item.cmd          = CMD_LOAD;
      item.button       = btn_type'($urandom_range(3));
      item.load_hours   = 5'(hh);
      item.load_minutes = 6'(mm);
      item.load_seconds = 6'(ss);
      item.load_weekday = 3'(wd);
      item.load_date    = 5'(dd);
      item.load_month   = 4'(mo);
      item.load_year    = 7'(yy);
      return item;
   endfunction

   // Button press; the load fields carry random bits that the editor must ignore
   function automatic req_type make_press(btn_type btn);
      logic [63:0] raw;
      req_type     item;
      raw         = {$urandom, $urandom};
      item        = raw[REQ_BITS-1:0];
      item.cmd    = CMD_BUTTON;
      item.button = btn;
      return item;
   endfunction

   // Mostly legal current time, sometimes any bit pattern
   function automatic req_type random_load();
      logic [63:0] raw;
      req_type     item;
      if ($urandom_range(7) == 0) begin
         raw      = {$urandom, $urandom};
         item     = raw[REQ_BITS-1:0];
         item.cmd = CMD_LOAD;
         return item;
      end
      return make_load($urandom_range(23), $urandom_range(59), $urandom_range(59),
                       $urandom_range(7, 1), $urandom_range(31, 1), $urandom_range(12, 1),
                       $urandom_range(99));
   endfunction

   // One request transfer, with optional idle cycles ahead of it
   task automatic send_item(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   // Largest legal values: each field wraps up to its low bound and back down,
   // then next at review, confirm, cancel, and a press after the exit
   task automatic test_field_wrap();
      send_item(make_load(23, 59, 59, 7, 31, 12, 99));
      repeat (7) begin
         send_item(make_press(BTN_UP));
         send_item(make_press(BTN_DOWN));
         send_item(make_press(BTN_NEXT));
      end
      send_item(make_press(BTN_NEXT));
      send_item(make_press(BTN_UP));
      send_item(make_press(BTN_DOWN));
      send_item(make_press(BTN_BACK));
   endtask

   // Back at hours, and stepping of values loaded out of range
   task automatic test_back_and_odd_loads();
      send_item(make_load(31, 63, 63, 0, 0, 15, 127));
      send_item(make_press(BTN_BACK));
      send_item(make_press(BTN_DOWN));
      send_item(make_press(BTN_UP));
      repeat (3) send_item(make_press(BTN_NEXT));
      send_item(make_press(BTN_DOWN));
      send_item(make_load(0, 0, 0, 1, 1, 1, 0));
      send_item(make_press(BTN_DOWN));
   endtask

   // Edit sessions: a load, a random walk of presses, often a walk to review and an exit;
   // some fully random transfers mixed in
   task automatic test_random_sessions(int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      logic [63:0] raw;
      req_type     noise;
      btn_type     btn;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(9) == 0) begin
            raw   = {$urandom, $urandom};
            noise = raw[REQ_BITS-1:0];
            send_item(noise);
         end else begin
            send_item(random_load());
            repeat ($urandom_range(30, 3)) begin
               pick = $urandom_range(99);
               if (pick < 15) btn = BTN_BACK;
               else if (pick < 45) btn = BTN_NEXT;
               else if (pick < 72) btn = BTN_UP;
               else btn = BTN_DOWN;
               send_item(make_press(btn));
            end
            if ($urandom_range(1) == 1) begin
               repeat (7) send_item(make_press(BTN_NEXT));
               send_item(make_press($urandom_range(1) ? BTN_UP : BTN_DOWN));
            end
         end
      end
   endtask

   task automatic set_pacing(int unsigned send_pct, int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      reset         <= 1'b1;
      sel_pos           = POS_HOURS;
      edit_time         = '0;
      edit_time.weekday = 3'd1;
      edit_time.date    = 5'd1;
      edit_time.month   = 4'd1;
      items_sent   = 0;
      loads_seen   = 0;
      presses_seen = 0;
      commits_seen = 0;
      leaves_seen  = 0;
      error_count  = 0;
      cycle_count  = 0;
      set_pacing(26, 51);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_field_wrap();
      test_back_and_odd_loads();
      test_random_sessions(ITEMS_PER_PHASE);
      set_pacing(51, 26);
      test_random_sessions(ITEMS_PER_PHASE);
      set_pacing(0, 0);
      test_random_sessions(ITEMS_PER_PHASE);
      req_bus.valid <= 1'b0;

      // Drain outstanding responses, then watch for strays
      while (expected_edits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transfers: %0d loads, %0d button presses, %0d commits, %0d exits,",
               items_sent, loads_seen, presses_seen, commits_seen, leaves_seen);
      $display("under three pacing mixes of sender gaps and response stalls; %0d errors.",
               error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/cste_pkg.sv
hw/rtl/cste_if.sv
hw/rtl/cste_in_stage.sv
hw/rtl/cste_edit_core.sv
hw/rtl/clock_set_time_editor_unit.sv
dv/tb_top.sv
